[design/rdiv_pkg.sv]
// Package for the pipelined unsigned 32-bit restoring divider.
// Request, response and pipeline stage types, and the one-bit division step.
// No dependencies.
`timescale 1ns / 1ps

package rdiv_pkg;

    // Operand width and pipeline depth: one stage per quotient bit
    localparam int unsigned DIV_WIDTH = 32;
    localparam int unsigned STAGES    = DIV_WIDTH;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] dividend;
        logic [DIV_WIDTH-1:0] divisor;
    } rdiv_req_t;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] quotient;
        logic [DIV_WIDTH-1:0] remainder;
        logic                 divide_by_zero;
    } rdiv_rsp_t;

    // Working state carried down the pipeline
    typedef struct packed {
        logic [DIV_WIDTH-1:0] rem;      // partial remainder
        logic [DIV_WIDTH-1:0] num;      // dividend bits still to go, next one at the top
        logic [DIV_WIDTH-1:0] quo;      // quotient bits so far, newest at the bottom
        logic [DIV_WIDTH-1:0] divisor;
    } rdiv_stage_t;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    // The remainder stays below the divisor (or is a dividend prefix when the
    // divisor is zero), so it always fits back into DIV_WIDTH bits.
    function automatic rdiv_stage_t rdiv_step(rdiv_stage_t s);
        logic [DIV_WIDTH:0] shifted;
        logic [DIV_WIDTH:0] diff;
        rdiv_stage_t        r;
        shifted   = {s.rem, s.num[DIV_WIDTH-1]};
        diff      = shifted - {1'b0, s.divisor};
        r         = s;
        r.num     = {s.num[DIV_WIDTH-2:0], 1'b0};
        if (shifted >= {1'b0, s.divisor})
        begin
            r.rem = diff[DIV_WIDTH-1:0];
            r.quo = {s.quo[DIV_WIDTH-2:0], 1'b1};
        end
        else
        begin
            r.rem = shifted[DIV_WIDTH-1:0];
            r.quo = {s.quo[DIV_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[design/restoring_divider_u32.sv]
// Top level of the pipelined unsigned 32-bit restoring divider.
// Uses rdiv_pkg for the request/response types and the division step.
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries dividend and divisor.
//   Response channel (rsp_valid/rsp_ready/rsp) carries quotient, remainder
//   and divide_by_zero, one response per request, in request order.
//   The datapath is 32 register stages, one quotient bit each, every stage
//   holding one 33-bit subtract and compare. A request accepted into the first
//   stage moves through the stages in order to the response port; the last
//   stage is the response register. Throughput is independent of operand
//   values: one request per cycle while the output is not stalled.
//   A zero divisor sets divide_by_zero and returns a quotient of all ones and
//   the dividend as remainder.
//   When the receiver holds rsp_ready low with a response waiting, the whole
//   pipe freezes and req_ready drops; nothing is lost or repeated. While the
//   last stage is empty the pipe keeps moving and bubbles drain through it.
//   Reset (rst_n low, asynchronous) empties all stages; in-flight requests
//   are dropped.
`timescale 1ns / 1ps

module restoring_divider_u32 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rdiv_pkg::rdiv_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rdiv_pkg::rdiv_rsp_t rsp
);

    logic                  valid_reg [rdiv_pkg::STAGES];
    rdiv_pkg::rdiv_stage_t stage_reg [rdiv_pkg::STAGES];
    rdiv_pkg::rdiv_stage_t stage_next[rdiv_pkg::STAGES];
    rdiv_pkg::rdiv_stage_t first;
    logic                  advance;

    // Whole pipe moves unless a response is stuck at the output
    assign advance   = !valid_reg[rdiv_pkg::STAGES-1] || rsp_ready;
    assign req_ready = advance;

    // Step logic, one per stage
    always_comb
    begin
        first.rem     = '0;
        first.num     = req.dividend;
        first.quo     = '0;
        first.divisor = req.divisor;
        stage_next[0] = rdiv_pkg::rdiv_step(first);
        for (int k = 1; k < rdiv_pkg::STAGES; k++)
        begin
            stage_next[k] = rdiv_pkg::rdiv_step(stage_reg[k-1]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rdiv_pkg::STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= req_valid;
            for (int k = 1; k < rdiv_pkg::STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < rdiv_pkg::STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Response from the last stage
    assign rsp_valid          = valid_reg[rdiv_pkg::STAGES-1];
    assign rsp.quotient       = stage_reg[rdiv_pkg::STAGES-1].quo;
    assign rsp.remainder      = stage_reg[rdiv_pkg::STAGES-1].rem;
    assign rsp.divide_by_zero = (stage_reg[rdiv_pkg::STAGES-1].divisor == '0);

endmodule

[design/rdiv_checker.sv]
// Port-level checker for restoring_divider_u32, attached by bind.
// Depends on rdiv_pkg for the request/response types.
`timescale 1ns / 1ps

module rdiv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input rdiv_pkg::rdiv_req_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rdiv_pkg::rdiv_rsp_t rsp
);

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A stalled output freezes the pipe, so no new request may enter
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while output stalled");

    // With the output empty the pipe always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty output");

    // Divide by zero yields a quotient of all ones
    a_dbz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |-> rsp.quotient == '1)
        else $error("zero divisor gave wrong quotient");

endmodule

bind restoring_divider_u32 rdiv_checker u_rdiv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
